@@ hdl/hevc_tsm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hevc_tsm_pkg
// Codes and fixed constants of the tile scan address map.
// ----------------------------------------------------------------------------
package hevc_tsm_pkg;

  localparam int LOAD_SLOTS         = 32;
  localparam int LOAD_AW            = 5;
  localparam int MAX_UNITS_PER_SIDE = 512;

  localparam logic [2:0] ACT_LOAD_COL = 3'd0;
  localparam logic [2:0] ACT_LOAD_ROW = 3'd1;
  localparam logic [2:0] ACT_PREPARE  = 3'd2;
  localparam logic [2:0] ACT_TO_TILE  = 3'd3;
  localparam logic [2:0] ACT_TO_RAST  = 3'd4;
  localparam logic [2:0] ACT_TILE_AT  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOLAY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [2:0] CFG_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_TILING = 3'd2;
  localparam logic [2:0] CFG_COLS   = 3'd3;
  localparam logic [2:0] CFG_ROWS   = 3'd4;
  localparam logic [2:0] CFG_EVEN   = 3'd5;
  localparam logic [2:0] CFG_LOG2   = 3'd6;

endpackage

@@ hdl/hevc_tile_scan_address_map.sv @@
`timescale 1ns / 1ps
// Loads, and items that fail their entry checks, answer in the cycle after start.
// With more than one tile, an off-picture luma query is rejected in S_LU_CHK.
// Prepare runs a 20-step divide per tile column and row with even spacing, else
// reads the loaded sizes. Conversions scan the boundaries (S_SCAN_A, S_SCAN_B)
// and run a 20-step divide. One item at a time; results are never stalled.
// Synchronous reset restores the register defaults and leaves no layout prepared.
// ----------------------------------------------------------------------------
// hevc_tile_scan_address_map
// Tile layout of a CTU grid and conversions between raster and tile scan.
// ----------------------------------------------------------------------------
module hevc_tile_scan_address_map #(
  parameter int MAX_TILE_COLUMNS = 32,
  parameter int MAX_TILE_ROWS    = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [9:0]  wr_data,
  input  logic [2:0]  action,
  input  logic [4:0]  entry_index,
  input  logic [9:0]  entry_size,
  input  logic [17:0] unit_address,
  input  logic [14:0] luma_x,
  input  logic [14:0] luma_y,
  output logic        done,
  output logic [1:0]  status,
  output logic [17:0] converted_address,
  output logic [9:0]  tile_number
);
  import hevc_tsm_pkg::*;

  localparam int MAXT = (MAX_TILE_COLUMNS > MAX_TILE_ROWS) ? MAX_TILE_COLUMNS : MAX_TILE_ROWS;
  localparam int CW   = $clog2(MAXT + 1);
  localparam int CAW  = $clog2(MAX_TILE_COLUMNS + 1);
  localparam int RAW  = $clog2(MAX_TILE_ROWS + 1);
  localparam logic [4:0] DIV_LAST = 5'd19;

  typedef enum logic [4:0] {
    S_IDLE, S_DIV, S_SCAN_A, S_SCAN_B,
    S_PREP_INIT, S_PREP_STEP, S_PREP_EVEN, S_PREP_LD,
    S_RT_DIVD, S_RT_COL, S_RT_ROW, S_RT_M1, S_RT_M2, S_RT_M3,
    S_TR_ROW, S_TR_COL, S_TR_DIVD, S_TR_FIN, S_LU_CHK
  } state_t;

  state_t state, ret;

  logic [9:0]  width_in_units, height_in_units;
  logic        tiling_on, even_spacing;
  logic [5:0]  tile_column_count, tile_row_count;
  logic [2:0]  unit_size_log2;
  logic        layout_ready;
  logic [12:0] tile_total;
  logic [19:0] unit_count;

  logic [9:0] col_size [LOAD_SLOTS];
  logic [9:0] row_size [LOAD_SLOTS];
  logic [9:0] col_bd [MAX_TILE_COLUMNS + 1];
  logic [9:0] row_bd [MAX_TILE_ROWS + 1];
  logic [9:0] ld_q, col_q, row_q;

  logic          bd_we, bd_wdim;
  logic [CW-1:0] bd_waddr;
  logic [9:0]    bd_wdata;

  logic [2:0]    act;
  logic [17:0]   addr;
  logic          dim, sdim;
  logic [CW-1:0] j, k, sn, trow, tcol;
  logic [9:0]    lo, hi, scale, prev, rlo, rhi, clo, chi, tx, ty;
  logic [19:0]   v, acc;
  logic [15:0]   used;
  logic [25:0]   rs;
  logic [19:0]   dv_num;
  logic [9:0]    dv_rem, dv_den;
  logic [4:0]    dv_cnt;

  logic [5:0]  nc, nr, pn;
  logic [9:0]  pside, bd_d, sz;
  logic [10:0] dv_try;
  logic        accept, bad_layout, plast;
  logic [15:0] used_sum;

  assign nc     = tiling_on ? tile_column_count : 6'd1;
  assign nr     = tiling_on ? tile_row_count : 6'd1;
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign pside  = dim ? height_in_units : width_in_units;
  assign pn     = dim ? nr : nc;
  assign plast  = ((CW + 1)'(j) + 1'b1) == (CW + 1)'(pn);
  assign bd_d   = sdim ? row_q : col_q;
  assign dv_try = {dv_rem, dv_num[19]};

  assign bad_layout = (nc == 6'd0) || (nr == 6'd0)
                   || ({4'b0, nc} > width_in_units) || ({4'b0, nr} > height_in_units)
                   || (32'(nc) > MAX_TILE_COLUMNS) || (32'(nr) > MAX_TILE_ROWS)
                   || (32'(width_in_units) > MAX_UNITS_PER_SIDE)
                   || (32'(height_in_units) > MAX_UNITS_PER_SIDE);

  // Size of the current tile column or row with loaded sizes; the last one
  // takes what is left of the picture side.
  always_comb begin
    if (plast) begin
      sz = (used >= 16'(pside)) ? 10'd0 : 10'(16'(pside) - used);
    end else begin
      sz = (32'(j) < LOAD_SLOTS) ? ld_q : 10'd0;
    end
    used_sum = used + 16'(sz);
  end

  // Size tables: written by load items, read by prepare through the registered ld_q.
  always_ff @(posedge clk) begin
    if (accept && action == ACT_LOAD_COL && 32'(entry_index) < MAX_TILE_COLUMNS) begin
      col_size[entry_index] <= entry_size;
    end
    if (accept && action == ACT_LOAD_ROW && 32'(entry_index) < MAX_TILE_ROWS) begin
      row_size[entry_index] <= entry_size;
    end
    ld_q <= dim ? row_size[j[LOAD_AW-1:0]] : col_size[j[LOAD_AW-1:0]];
  end

  // Boundary tables.
  always_ff @(posedge clk) begin
    if (bd_we && !bd_wdim) begin
      col_bd[bd_waddr[CAW-1:0]] <= bd_wdata;
    end
    if (bd_we && bd_wdim) begin
      row_bd[bd_waddr[RAW-1:0]] <= bd_wdata;
    end
    col_q <= col_bd[j[CAW-1:0]];
    row_q <= row_bd[j[RAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      ret               <= S_IDLE;
      done              <= 1'b0;
      bd_we             <= 1'b0;
      width_in_units    <= 10'd1;
      height_in_units   <= 10'd1;
      tiling_on         <= 1'b0;
      tile_column_count <= 6'd1;
      tile_row_count    <= 6'd1;
      even_spacing      <= 1'b1;
      unit_size_log2    <= 3'd4;
      layout_ready      <= 1'b0;
      tile_total        <= 13'd1;
      unit_count        <= 20'd1;
    end else begin
      done  <= 1'b0;
      bd_we <= 1'b0;

      if (wr_en) begin
        case (wr_index)
          CFG_WIDTH: begin
            width_in_units <= wr_data;
            unit_count     <= 20'(wr_data) * 20'(height_in_units);
            layout_ready   <= 1'b0;
          end
          CFG_HEIGHT: begin
            height_in_units <= wr_data;
            unit_count      <= 20'(width_in_units) * 20'(wr_data);
            layout_ready    <= 1'b0;
          end
          CFG_TILING: begin
            tiling_on    <= wr_data[0];
            layout_ready <= 1'b0;
          end
          CFG_COLS: begin
            tile_column_count <= wr_data[5:0];
            layout_ready      <= 1'b0;
          end
          CFG_ROWS: begin
            tile_row_count <= wr_data[5:0];
            layout_ready   <= 1'b0;
          end
          CFG_EVEN: begin
            even_spacing <= wr_data[0];
            layout_ready <= 1'b0;
          end
          CFG_LOG2: begin
            unit_size_log2 <= wr_data[2:0];
            layout_ready   <= 1'b0;
          end
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            act  <= action;
            addr <= unit_address;
            converted_address <= 18'd0;
            tile_number       <= 10'd0;
            if (action == ACT_LOAD_COL || action == ACT_LOAD_ROW) begin
              done   <= 1'b1;
              status <= ST_OK;
            end else if (action == ACT_PREPARE) begin
              layout_ready <= 1'b0;
              if (bad_layout) begin
                done   <= 1'b1;
                status <= ST_NOLAY;
              end else begin
                dim   <= 1'b0;
                state <= S_PREP_INIT;
              end
            end else if (action > ACT_TILE_AT || !layout_ready) begin
              done   <= 1'b1;
              status <= ST_NOLAY;
            end else if (action == ACT_TILE_AT) begin
              if (tile_total > 13'd1) begin
                rs <= 26'(luma_y >> unit_size_log2) * 26'(width_in_units)
                    + 26'(luma_x >> unit_size_log2);
                state <= S_LU_CHK;
              end else begin
                done   <= 1'b1;
                status <= ST_OK;
              end
            end else if (20'(unit_address) >= unit_count) begin
              done   <= 1'b1;
              status <= ST_RANGE;
            end else if (action == ACT_TO_TILE) begin
              dv_num <= 20'(unit_address);
              dv_rem <= 10'd0;
              dv_den <= width_in_units;
              dv_cnt <= 5'd0;
              ret    <= S_RT_DIVD;
              state  <= S_DIV;
            end else begin
              v     <= 20'(unit_address);
              scale <= width_in_units;
              sdim  <= 1'b1;
              sn    <= CW'(nr);
              j     <= '0;
              k     <= '0;
              ret   <= S_TR_ROW;
              state <= S_SCAN_A;
            end
          end
        end

        // Restoring divider, one quotient bit a cycle.
        S_DIV: begin
          if (dv_try >= {1'b0, dv_den}) begin
            dv_rem <= 10'(dv_try - {1'b0, dv_den});
            dv_num <= {dv_num[18:0], 1'b1};
          end else begin
            dv_rem <= dv_try[9:0];
            dv_num <= {dv_num[18:0], 1'b0};
          end
          dv_cnt <= dv_cnt + 5'd1;
          if (dv_cnt == DIV_LAST) begin
            state <= ret;
          end
        end

        // Band search: k is the last band whose scaled start is not above v;
        // lo and hi are the bounds of that band.
        S_SCAN_A: state <= S_SCAN_B;
        S_SCAN_B: begin
          if (j != sn && v >= 20'(scale) * 20'(bd_d)) begin
            k  <= j;
            lo <= bd_d;
          end else if ((CW + 1)'(k) + 1'b1 == (CW + 1)'(j)) begin
            hi <= bd_d;
          end
          if (j == sn) begin
            state <= ret;
          end else begin
            j     <= j + 1'b1;
            state <= S_SCAN_A;
          end
        end

        S_PREP_INIT: begin
          bd_we    <= 1'b1;
          bd_wdim  <= dim;
          bd_waddr <= '0;
          bd_wdata <= 10'd0;
          j        <= '0;
          used     <= 16'd0;
          prev     <= 10'd0;
          state    <= S_PREP_STEP;
        end

        S_PREP_STEP: begin
          if (even_spacing) begin
            dv_num <= (20'(j) + 20'd1) * 20'(pside);
            dv_rem <= 10'd0;
            dv_den <= 10'(pn);
            dv_cnt <= 5'd0;
            ret    <= S_PREP_EVEN;
            state  <= S_DIV;
          end else begin
            state <= S_PREP_LD;
          end
        end

        S_PREP_EVEN, S_PREP_LD: begin
          if ((state == S_PREP_EVEN && dv_num[9:0] == prev)
              || (state == S_PREP_LD && sz == 10'd0)) begin
            done   <= 1'b1;
            status <= ST_NOLAY;
            state  <= S_IDLE;
          end else begin
            bd_we    <= 1'b1;
            bd_wdim  <= dim;
            bd_waddr <= j + 1'b1;
            bd_wdata <= (state == S_PREP_EVEN) ? dv_num[9:0] : used_sum[9:0];
            prev     <= dv_num[9:0];
            used     <= used_sum;
            if (!plast) begin
              j     <= j + 1'b1;
              state <= S_PREP_STEP;
            end else if (!dim) begin
              dim   <= 1'b1;
              state <= S_PREP_INIT;
            end else begin
              layout_ready <= 1'b1;
              tile_total   <= 13'(12'(nc) * 12'(nr));
              done         <= 1'b1;
              status       <= ST_OK;
              state        <= S_IDLE;
            end
          end
        end

        S_LU_CHK: begin
          if (rs >= 26'(unit_count)) begin
            done   <= 1'b1;
            status <= ST_RANGE;
            state  <= S_IDLE;
          end else begin
            dv_num <= rs[19:0];
            dv_rem <= 10'd0;
            dv_den <= width_in_units;
            dv_cnt <= 5'd0;
            ret    <= S_RT_DIVD;
            state  <= S_DIV;
          end
        end

        S_RT_DIVD: begin
          ty    <= dv_num[9:0];
          tx    <= dv_rem;
          v     <= 20'(dv_rem);
          scale <= 10'd1;
          sdim  <= 1'b0;
          sn    <= CW'(nc);
          j     <= '0;
          k     <= '0;
          ret   <= S_RT_COL;
          state <= S_SCAN_A;
        end

        S_RT_COL: begin
          tcol  <= k;
          clo   <= lo;
          chi   <= hi;
          v     <= 20'(ty);
          sdim  <= 1'b1;
          sn    <= CW'(nr);
          j     <= '0;
          k     <= '0;
          ret   <= S_RT_ROW;
          state <= S_SCAN_A;
        end

        S_RT_ROW: begin
          trow <= k;
          rlo  <= lo;
          rhi  <= hi;
          if (act == ACT_TILE_AT) begin
            done        <= 1'b1;
            status      <= ST_OK;
            tile_number <= 10'(12'(k) * 12'(nc) + 12'(tcol));
            state       <= S_IDLE;
          end else begin
            acc   <= 20'(width_in_units) * 20'(lo);
            state <= S_RT_M1;
          end
        end

        S_RT_M1: begin
          acc   <= acc + 20'(rhi - rlo) * 20'(clo);
          state <= S_RT_M2;
        end

        S_RT_M2: begin
          acc   <= acc + 20'(ty - rlo) * 20'(chi - clo);
          state <= S_RT_M3;
        end

        S_RT_M3: begin
          done              <= 1'b1;
          status            <= ST_OK;
          converted_address <= 18'(acc + 20'(tx) - 20'(clo));
          tile_number       <= 10'(12'(trow) * 12'(nc) + 12'(tcol));
          state             <= S_IDLE;
        end

        S_TR_ROW: begin
          trow  <= k;
          rlo   <= lo;
          v     <= 20'(addr) - 20'(width_in_units) * 20'(lo);
          scale <= hi - lo;
          sdim  <= 1'b0;
          sn    <= CW'(nc);
          j     <= '0;
          k     <= '0;
          ret   <= S_TR_COL;
          state <= S_SCAN_A;
        end

        S_TR_COL: begin
          tcol   <= k;
          clo    <= lo;
          dv_num <= v - 20'(scale) * 20'(lo);
          dv_rem <= 10'd0;
          dv_den <= hi - lo;
          dv_cnt <= 5'd0;
          ret    <= S_TR_DIVD;
          state  <= S_DIV;
        end

        S_TR_DIVD: begin
          ty    <= rlo + dv_num[9:0];
          tx    <= clo + dv_rem;
          state <= S_TR_FIN;
        end

        S_TR_FIN: begin
          done              <= 1'b1;
          status            <= ST_OK;
          converted_address <= 18'(20'(ty) * 20'(width_in_units) + 20'(tx));
          tile_number       <= 10'(12'(trow) * 12'(nc) + 12'(tcol));
          state             <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A result always closes its item, so the block is free again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while still busy");

  a_load_one: assert property (@(posedge clk) disable iff (rst)
    (accept && (action == ACT_LOAD_COL || action == ACT_LOAD_ROW))
      |=> (done && status == ST_OK))
    else $error("load item did not answer in one cycle");

  a_tile_total: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_OK && tile_number != 10'd0) |-> (tile_total > 13'd1))
    else $error("nonzero tile with a single-tile layout");

  a_ready_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_RT_M3 || state == S_TR_FIN) |-> layout_ready)
    else $error("conversion finished without a prepared layout");
`endif

endmodule
